// File: rtl/sql_token_scanner_macros.svh
// assertion helpers for the token scanner checks
`ifndef SQL_TOKEN_SCANNER_MACROS_SVH
`define SQL_TOKEN_SCANNER_MACROS_SVH

// plain property, sampled on the clock, off while in reset
`define STS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sql_token_scanner check failed");

// overlapping implication
`define STS_ASSERT_IMPL(name, ante, cons) \
  `STS_ASSERT(name, (ante) |-> (cons))

// implication on the next cycle
`define STS_ASSERT_NEXT(name, ante, cons) \
  `STS_ASSERT(name, (ante) |=> (cons))

`endif

// File: rtl/sts_pkg.sv
`default_nettype none

package sts_pkg;

  // default sizes
  localparam int TEXT_BYTES_DEF  = 256;
  localparam int OFFSET_BITS_DEF = 16;

  // token queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // token kinds
  localparam logic [5:0] KIND_END        = 6'd0;
  localparam logic [5:0] KIND_IDENT      = 6'd1;
  localparam logic [5:0] KIND_NUMBER     = 6'd2;
  localparam logic [5:0] KIND_STRING     = 6'd3;
  localparam logic [5:0] KIND_UNKNOWN    = 6'd4;
  localparam logic [5:0] KIND_PUNCT_BASE = 6'd5;
  localparam logic [5:0] KIND_GE         = 6'd13;
  localparam logic [5:0] KIND_LE         = 6'd14;
  localparam logic [5:0] KIND_NE         = 6'd15;
  localparam logic [5:0] KIND_ET         = 6'd16;
  localparam logic [5:0] KIND_GT         = 6'd17;
  localparam logic [5:0] KIND_LT         = 6'd18;
  localparam logic [5:0] KIND_KW_BASE    = 6'd19;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  localparam logic [7:0] PUNCT_CHARS [8] = '{
    8'h2c, 8'h3b, 8'h28, 8'h29, 8'h2b, 8'h2d, 8'h2a, 8'h2f
  };

  // keyword table, text right-justified, last char in the low byte
  localparam int NUM_KW = 22;
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    "CREATE", "DROP", "DELETE", "TRUNCATE", "UPDATE", "ALTER", "SELECT",
    "INSERT", "DATABASE", "TABLE", "FROM", "WHERE", "AND", "OR", "NOT",
    "BETWEEN", "LIKE", "IN", "IS", "NULL", "INTO", "VALUES"
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd6, 4'd4, 4'd6, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd8, 4'd5, 4'd4,
    4'd5, 4'd3, 4'd2, 4'd3, 4'd7, 4'd4, 4'd2, 4'd2, 4'd4, 4'd4, 4'd6
  };

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_HELD
  } mode_e;

  typedef enum logic [1:0] {
    HELD_GT,
    HELD_LT,
    HELD_BANG
  } held_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [7:0]  length;
  } token_t;

  // tokens caused by one input byte: one, or two when pair is set
  typedef struct packed {
    logic   pair;
    token_t first;
    token_t second;
  } group_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'h09:8'h0d], CH_SPACE};
  endfunction

  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    logic [5:0] res;
    res = KIND_UNKNOWN;
    for (int i = 0; i < 8; i++) begin
      if (PUNCT_CHARS[i] == c) res = KIND_PUNCT_BASE + 6'(i);
    end
    return res;
  endfunction

  // drop keywords whose char at position p differs from c
  function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] cand,
                                                  input logic [7:0] c,
                                                  input logic p_small,
                                                  input logic [2:0] p_lo);
    logic [NUM_KW-1:0] res;
    logic [7:0]        u;
    logic [3:0]        idx;
    res = cand;
    u   = (c inside {[8'h61:8'h7a]}) ? c - 8'd32 : c;
    for (int k = 0; k < NUM_KW; k++) begin
      idx = KW_LEN[k] - 4'd1 - {1'b0, p_lo};
      if (!p_small || {1'b0, p_lo} >= KW_LEN[k] ||
          KW_TEXT[k][{idx[2:0], 3'b000} +: 8] != u) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  // first surviving keyword of the run length, else identifier
  function automatic logic [5:0] kw_kind(input logic [NUM_KW-1:0] cand,
                                         input logic l_fit,
                                         input logic [3:0] l_lo);
    logic [5:0] res;
    res = KIND_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cand[k] && l_fit && KW_LEN[k] == l_lo) res = KIND_KW_BASE + 6'(k);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sts_if.sv
`default_nettype none

// statement byte channel
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

// token channel
interface sts_tok_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [15:0] token_start;
  logic [7:0]  token_length;
  logic        last_in_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_in_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last_in_run, output ready);
endinterface

`default_nettype wire

// File: rtl/sql_token_scanner.sv
`default_nettype none

// channel  | dir | beat                                         | taken when
// in_i     | in  | char_code, one statement byte (0 ends it)    | valid && ready
// tok_o    | out | token_kind, token_start, token_length, last  | valid && ready
//
// one byte is taken per cycle while the token queue has room; a byte gives
// zero, one or two tokens, and the back end sends one token per cycle while
// the sink is ready, so a byte that closes a run and emits its own token gives
// two tokens in turn. a byte's first token is written to the queue as the byte
// is taken, then to the output register when that is free or draining.
// reset is asynchronous, active low, and leaves the scanner between tokens.
// a stalled token sink backs up into the queue and then drops in_i ready.

module sql_token_scanner #(
  parameter int TEXT_BYTES  = sts_pkg::TEXT_BYTES_DEF,
  parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sts_in_if.sink     in_i,
  sts_tok_if.source  tok_o
);
  import sts_pkg::*;

  logic   full, empty, push, pop;
  group_t push_group, head;

  // byte classification and run tracking
  sts_front #(
    .TEXT_BYTES  (TEXT_BYTES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .char_code_i  (in_i.char_code),
    .in_ready_o   (in_i.ready),
    .full_i       (full),
    .push_o       (push),
    .push_group_o (push_group)
  );

  // token groups between front and back
  sts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty)
  );

  // token output
  sts_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .tok_valid_o    (tok_o.valid),
    .tok_ready_i    (tok_o.ready),
    .token_kind_o   (tok_o.token_kind),
    .token_start_o  (tok_o.token_start),
    .token_length_o (tok_o.token_length),
    .last_in_run_o  (tok_o.last_in_run)
  );

endmodule

`default_nettype wire

// File: rtl/sts_front.sv
`default_nettype none

module sts_front #(
  parameter int TEXT_BYTES  = sts_pkg::TEXT_BYTES_DEF,
  parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      char_code_i,
  output logic                 in_ready_o,
  input  wire logic            full_i,
  output logic                 push_o,
  output sts_pkg::group_t      push_group_o
);
  import sts_pkg::*;

  localparam int LEN_W = $clog2(TEXT_BYTES);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(TEXT_BYTES - 1);

  mode_e                  mode_q, mode_d;
  held_e                  held_q, held_d;
  logic                   dot_q, dot_d;
  logic [NUM_KW-1:0]      cand_q, cand_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;

  logic             accept;
  logic [7:0]       c;
  logic             cont;
  logic             consumed;
  logic             tok_a_valid, tok_b_valid;
  token_t           tok_a, tok_b;
  logic [LEN_W-1:0] len_inc;
  logic [OFFSET_BITS-1:0] off_inc;
  logic             p_small;
  logic             l_fit;
  logic             fresh_run;

  assign c          = char_code_i;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign len_inc = (len_q < LEN_MAX) ? len_q + 1'b1 : len_q;
  assign off_inc = (&off_q) ? off_q : off_q + 1'b1;
  assign p_small = len_q < LEN_W'(8);
  assign l_fit   = {1'b0, len_q} < (LEN_W+1)'(16);

  // does the byte extend the open run
  always_comb begin
    case (mode_q)
      MODE_STRING: cont = (c != CH_NUL) && (c != CH_QUOTE);
      MODE_IDENT:  cont = is_alpha(c) || is_digit(c) || (c == CH_UNDER);
      MODE_NUMBER: cont = is_digit(c) || ((c == CH_DOT) && !dot_q);
      default:     cont = 1'b0;
    endcase
  end

  assign consumed = cont || ((mode_q == MODE_STRING) && (c == CH_QUOTE)) ||
                    ((mode_q == MODE_HELD) && (c == CH_EQ));

  // bytes that open a run, or blanks, and emit no token of their own yet
  assign fresh_run = is_space(c) || (c == CH_GT) || (c == CH_LT) ||
                     (c == CH_BANG) || (c == CH_QUOTE) || is_digit(c) ||
                     is_alpha(c) || (c == CH_UNDER);

  // next state
  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    dot_d   = dot_q;
    cand_d  = cand_q;
    start_d = start_q;
    len_d   = len_q;
    off_d   = off_inc;
    if (mode_q != MODE_IDLE) begin
      if (cont) begin
        len_d = len_inc;
        if (mode_q == MODE_IDENT) cand_d = kw_filter(cand_q, c, p_small, len_q[2:0]);
        if (mode_q == MODE_NUMBER && c == CH_DOT) dot_d = 1'b1;
      end else begin
        mode_d = MODE_IDLE;
      end
    end
    if (!consumed) begin
      if (c == CH_NUL) begin
        mode_d  = MODE_IDLE;
        held_d  = HELD_GT;
        dot_d   = 1'b0;
        cand_d  = '1;
        start_d = '0;
        len_d   = '0;
        off_d   = '0;
      end else if (c == CH_GT || c == CH_LT || c == CH_BANG) begin
        mode_d  = MODE_HELD;
        held_d  = (c == CH_GT) ? HELD_GT : (c == CH_LT) ? HELD_LT : HELD_BANG;
        start_d = off_q;
      end else if (c == CH_QUOTE) begin
        mode_d  = MODE_STRING;
        start_d = off_inc;
        len_d   = '0;
      end else if (is_digit(c)) begin
        mode_d  = MODE_NUMBER;
        start_d = off_q;
        len_d   = LEN_W'(1);
        dot_d   = 1'b0;
      end else if (is_alpha(c) || c == CH_UNDER) begin
        mode_d  = MODE_IDENT;
        start_d = off_q;
        len_d   = LEN_W'(1);
        cand_d  = kw_filter('1, c, 1'b1, 3'd0);
      end
    end
  end

  // tokens caused by this byte
  always_comb begin
    tok_a.start  = 16'(start_q);
    tok_a.length = 8'(len_q);
    tok_a.kind   = KIND_STRING;
    tok_a_valid  = (mode_q != MODE_IDLE) && !cont;
    case (mode_q)
      MODE_STRING: tok_a.kind = KIND_STRING;
      MODE_IDENT:  tok_a.kind = kw_kind(cand_q, l_fit, len_q[3:0]);
      MODE_NUMBER: tok_a.kind = KIND_NUMBER;
      MODE_HELD: begin
        if (c == CH_EQ) begin
          tok_a.length = 8'd2;
          tok_a.kind   = (held_q == HELD_GT) ? KIND_GE :
                         (held_q == HELD_LT) ? KIND_LE : KIND_NE;
        end else begin
          tok_a.length = 8'd1;
          tok_a.kind   = (held_q == HELD_GT) ? KIND_GT :
                         (held_q == HELD_LT) ? KIND_LT : KIND_UNKNOWN;
        end
      end
      default: tok_a.kind = KIND_STRING;
    endcase

    tok_b.start  = 16'(off_q);
    tok_b_valid  = !consumed && !fresh_run;
    if (c == CH_NUL) begin
      tok_b.kind   = KIND_END;
      tok_b.length = 8'd0;
    end else if (c == CH_EQ) begin
      tok_b.kind   = KIND_ET;
      tok_b.length = 8'd1;
    end else begin
      tok_b.kind   = punct_kind(c);
      tok_b.length = 8'd1;
    end
  end

  // pack the beat's tokens for the queue
  assign push_o              = accept && (tok_a_valid || tok_b_valid);
  assign push_group_o.pair   = tok_a_valid && tok_b_valid;
  assign push_group_o.first  = tok_a_valid ? tok_a : tok_b;
  assign push_group_o.second = tok_b;

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      held_q  <= HELD_GT;
      dot_q   <= 1'b0;
      cand_q  <= '1;
      start_q <= '0;
      len_q   <= '0;
      off_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      held_q  <= held_d;
      dot_q   <= dot_d;
      cand_q  <= cand_d;
      start_q <= start_d;
      len_q   <= len_d;
      off_q   <= off_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sts_queue.sv
`default_nettype none

module sts_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  sts_pkg::group_t push_group_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output sts_pkg::group_t head_o,
  output logic            empty_o
);
  import sts_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  group_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_group_i;
  end

endmodule

`default_nettype wire

// File: rtl/sts_back.sv
`default_nettype none

module sts_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  sts_pkg::group_t head_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  output logic            tok_valid_o,
  input  wire logic       tok_ready_i,
  output logic [5:0]      token_kind_o,
  output logic [15:0]     token_start_o,
  output logic [7:0]      token_length_o,
  output logic            last_in_run_o
);
  import sts_pkg::*;

  logic   out_valid_q, out_valid_d;
  token_t out_tok_q, out_tok_d;
  logic   out_last_q, out_last_d;
  logic   sel_q, sel_d;
  logic   load;

  // output register free or being drained this cycle
  assign load = !out_valid_q || tok_ready_i;

  // pick the next token of the head group
  always_comb begin
    out_valid_d = out_valid_q;
    out_tok_d   = out_tok_q;
    out_last_d  = out_last_q;
    sel_d       = sel_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !empty_i;
      out_tok_d   = sel_q ? head_i.second : head_i.first;
      out_last_d  = sel_q || !head_i.pair;
      if (!empty_i) begin
        pop_o = out_last_d;
        sel_d = !out_last_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  // token payload
  always_ff @(posedge clk_i) begin
    out_tok_q  <= out_tok_d;
    out_last_q <= out_last_d;
  end

  assign tok_valid_o    = out_valid_q;
  assign token_kind_o   = out_tok_q.kind;
  assign token_start_o  = out_tok_q.start;
  assign token_length_o = out_tok_q.length;
  assign last_in_run_o  = out_last_q;

endmodule

`default_nettype wire

// File: rtl/sts_checker.sv
`default_nettype none

`include "sql_token_scanner_macros.svh"

module sts_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        tok_valid_i,
  input  wire logic        tok_ready_i,
  input  wire logic [5:0]  token_kind_i,
  input  wire logic [15:0] token_start_i,
  input  wire logic [7:0]  token_length_i,
  input  wire logic        last_in_run_i
);
  import sts_pkg::*;

  logic        tok_take;
  logic        tok_stall;
  logic [30:0] tok_beat;
  logic        two_char_op;

  assign tok_take    = tok_valid_i && tok_ready_i;
  assign tok_stall   = tok_valid_i && !tok_ready_i;
  assign tok_beat    = {token_kind_i, token_start_i, token_length_i, last_in_run_i};
  assign two_char_op = token_kind_i inside {KIND_GE, KIND_LE, KIND_NE};

  // stalled token holds
  `STS_ASSERT_NEXT(a_tok_hold, tok_stall, tok_valid_i && $stable(tok_beat))

  // end token closes its byte's run and has no text
  `STS_ASSERT_IMPL(a_end_last, tok_valid_i && token_kind_i == KIND_END, last_in_run_i && token_length_i == 8'd0)

  // second token of a byte follows right after the first
  `STS_ASSERT_NEXT(a_pair_follows, tok_take && !last_in_run_i, tok_valid_i)

  // only defined kinds leave the block
  `STS_ASSERT_IMPL(a_kind_range, tok_valid_i, token_kind_i <= 6'd40)

  // compare ops of two chars are length two
  `STS_ASSERT_IMPL(a_op_len, tok_valid_i && two_char_op, token_length_i == 8'd2)

endmodule

bind sql_token_scanner sts_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .tok_valid_i    (tok_o.valid),
  .tok_ready_i    (tok_o.ready),
  .token_kind_i   (tok_o.token_kind),
  .token_start_i  (tok_o.token_start),
  .token_length_i (tok_o.token_length),
  .last_in_run_i  (tok_o.last_in_run)
);

`default_nettype wire

// File: dv/sql_token_scanner_tb.sv
module sql_token_scanner_tb;
  import sts_pkg::*;

  localparam int CYCLE_LIMIT  = 100_000;
  localparam int TAIL_CYCLES  = 16;
  localparam int TOTAL_ITEMS  = 1100;
  localparam int LONG_STRING  = 300;
  localparam logic [15:0] STALL_PAT = 16'b1101_0110_0111_1010;

  // one token as it leaves the scanner
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [7:0]  length;
    logic        last;
  } tok_t;

  // one statement byte, optionally with its token typed in
  typedef struct {
    logic [7:0] code;
    bit         typed;
    tok_t       tok;
    bit         hold;
  } row_t;

  string kw_spell [NUM_KW] = '{
    "CREATE", "DROP", "DELETE", "TRUNCATE", "UPDATE", "ALTER", "SELECT",
    "INSERT", "DATABASE", "TABLE", "FROM", "WHERE", "AND", "OR", "NOT",
    "BETWEEN", "LIKE", "IN", "IS", "NULL", "INTO", "VALUES"
  };
  string punct_set = ",;()+-*/";
  string op_text [7] = '{">=", "<=", "!=", "=", ">", "<", "!"};

  // directed statements: a few lone tokens with known results, then a mixed one
  row_t directed_rows [24] = '{
    '{"=",    1'b1, '{KIND_ET,         16'd0, 8'd1, 1'b1}, 1'b0},
    '{",",    1'b1, '{KIND_PUNCT_BASE, 16'd1, 8'd1, 1'b1}, 1'b0},
    '{8'hff,  1'b1, '{KIND_UNKNOWN,    16'd2, 8'd1, 1'b1}, 1'b0},
    '{8'h80,  1'b1, '{KIND_UNKNOWN,    16'd3, 8'd1, 1'b1}, 1'b0},
    '{CH_NUL, 1'b1, '{KIND_END,        16'd4, 8'd0, 1'b1}, 1'b0},
    '{"S",    1'b0, '0, 1'b0},
    '{"e",    1'b0, '0, 1'b0},
    '{"L",    1'b0, '0, 1'b0},
    '{"e",    1'b0, '0, 1'b0},
    '{"C",    1'b0, '0, 1'b0},
    '{"t",    1'b0, '0, 1'b0},
    '{">",    1'b0, '0, 1'b0},
    '{"=",    1'b0, '0, 1'b0},
    '{"1",    1'b0, '0, 1'b0},
    '{".",    1'b0, '0, 1'b0},
    '{"5",    1'b0, '0, 1'b0},
    '{".",    1'b0, '0, 1'b0},
    '{"!",    1'b0, '0, 1'b0},
    '{"_",    1'b0, '0, 1'b0},
    '{" ",    1'b0, '0, 1'b0},
    '{"<",    1'b0, '0, 1'b0},
    '{"'",    1'b0, '0, 1'b0},
    '{"z",    1'b0, '0, 1'b0},
    '{CH_NUL, 1'b0, '0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  sts_in_if  bytes_if ();
  sts_tok_if tokens_if ();

  sql_token_scanner i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (bytes_if),
    .tok_o  (tokens_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  row_t stim [$];
  tok_t tokens_due [$];
  int   drv_idx = 0;
  int   errors = 0;
  int   cycle_cnt = 0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   rx_style = 0;

  // scanner state as predicted
  mode_e       mode_q;
  logic        dot_q;
  logic [21:0] cand_q;
  logic [15:0] run_start_q;
  int          run_len_q;
  logic [15:0] offset_q;
  logic [7:0]  held_q;

  function automatic bit digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit word_ch(input logic [7:0] c);
    return letter_ch(c) || digit_ch(c) || c == CH_UNDER;
  endfunction

  function automatic bit blank_ch(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [15:0] offset_inc(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic tok_t mk_tok(input logic [5:0] kind, input logic [15:0] start,
                                  input int len);
    tok_t t;
    t = '{kind, start, 8'(len), 1'b0};
    return t;
  endfunction

  function automatic void clear_scan();
    mode_q      = MODE_IDLE;
    dot_q       = 1'b0;
    cand_q      = '1;
    run_start_q = '0;
    run_len_q   = 0;
    offset_q    = '0;
    held_q      = '0;
  endfunction

  function automatic void grow_run();
    if (run_len_q < 255) run_len_q++;
  endfunction

  // drop keywords whose letter at the current position differs
  function automatic void drop_keywords(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    for (int k = 0; k < NUM_KW; k++) begin
      if (run_len_q >= kw_spell[k].len() || kw_spell[k][run_len_q] != u) cand_q[k] = 1'b0;
    end
  endfunction

  function automatic logic [5:0] word_kind();
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand_q[k] && kw_spell[k].len() == run_len_q) return KIND_KW_BASE + 6'(k);
    end
    return KIND_IDENT;
  endfunction

  // one statement byte in, up to two tokens out
  function automatic void lex_byte(input logic [7:0] c, output tok_t toks [2], output int n);
    logic [15:0] off;
    logic [5:0]  k;
    bit          taken;
    off   = offset_q;
    n     = 0;
    taken = 1'b0;
    toks[0] = '0;
    toks[1] = '0;
    case (mode_q)
      MODE_STRING: begin
        if (c == CH_NUL || c == CH_QUOTE) begin
          toks[n] = mk_tok(KIND_STRING, run_start_q, run_len_q);
          n++;
          mode_q = MODE_IDLE;
          taken  = (c != CH_NUL);
        end else begin
          grow_run();
          taken = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (word_ch(c)) begin
          drop_keywords(c);
          grow_run();
          taken = 1'b1;
        end else begin
          toks[n] = mk_tok(word_kind(), run_start_q, run_len_q);
          n++;
          mode_q = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (digit_ch(c) || (c == CH_DOT && !dot_q)) begin
          if (c == CH_DOT) dot_q = 1'b1;
          grow_run();
          taken = 1'b1;
        end else begin
          toks[n] = mk_tok(KIND_NUMBER, run_start_q, run_len_q);
          n++;
          mode_q = MODE_IDLE;
        end
      end
      MODE_HELD: begin
        if (c == CH_EQ) begin
          k = (held_q == CH_GT) ? KIND_GE : (held_q == CH_LT) ? KIND_LE : KIND_NE;
          toks[n] = mk_tok(k, run_start_q, 2);
          taken = 1'b1;
        end else begin
          k = (held_q == CH_GT) ? KIND_GT : (held_q == CH_LT) ? KIND_LT : KIND_UNKNOWN;
          toks[n] = mk_tok(k, run_start_q, 1);
        end
        n++;
        mode_q = MODE_IDLE;
        held_q = '0;
      end
      default: mode_q = MODE_IDLE;
    endcase

    // byte not absorbed by a run: scan it fresh
    if (!taken) begin
      if (c == CH_NUL) begin
        toks[n] = mk_tok(KIND_END, off, 0);
        n++;
        clear_scan();
      end else if (blank_ch(c)) begin
      end else if (c == CH_GT || c == CH_LT || c == CH_BANG) begin
        mode_q      = MODE_HELD;
        held_q      = c;
        run_start_q = off;
      end else if (c == CH_EQ) begin
        toks[n] = mk_tok(KIND_ET, off, 1);
        n++;
      end else if (c == CH_QUOTE) begin
        mode_q      = MODE_STRING;
        run_start_q = offset_inc(off);
        run_len_q   = 0;
      end else if (digit_ch(c)) begin
        mode_q      = MODE_NUMBER;
        run_start_q = off;
        run_len_q   = 1;
        dot_q       = 1'b0;
      end else if (letter_ch(c) || c == CH_UNDER) begin
        mode_q      = MODE_IDENT;
        run_start_q = off;
        run_len_q   = 0;
        cand_q      = '1;
        drop_keywords(c);
        run_len_q   = 1;
      end else begin
        k = KIND_UNKNOWN;
        for (int i = 0; i < 8; i++) begin
          if (punct_set[i] == c) k = KIND_PUNCT_BASE + 6'(i);
        end
        toks[n] = mk_tok(k, off, 1);
        n++;
      end
    end

    if (!(c == CH_NUL && !taken)) offset_q = offset_inc(off);
    if (n > 0) toks[n-1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // stimulus building
  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? CH_SPACE : 8'(r);
  endfunction

  function automatic logic [7:0] pick_word();
    int r;
    r = $urandom_range(0, 62);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    if (r < 62) return 8'("a" + r - 36);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_lead();
    logic [7:0] c;
    c = pick_word();
    return digit_ch(c) ? CH_UNDER : c;
  endfunction

  function automatic logic [7:0] pick_content();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    return (c == CH_QUOTE) ? CH_DOT : c;
  endfunction

  function automatic void add_byte(input logic [7:0] c, input bit hold = 1'b0);
    row_t r;
    r.code  = c;
    r.typed = 1'b0;
    r.tok   = '0;
    r.hold  = hold;
    stim.push_back(r);
  endfunction

  function automatic void add_text(input string s, input bit mix_case);
    logic [7:0] c;
    for (int j = 0; j < s.len(); j++) begin
      c = s[j];
      if (mix_case && letter_ch(c) && $urandom_range(0, 1)) c = c + 8'd32;
      add_byte(c);
    end
  endfunction

  // one well-formed statement with random content, now and then broken
  function automatic void add_statement();
    int lexemes;
    bit open_str;
    lexemes  = $urandom_range(1, 12);
    open_str = 1'b0;
    for (int i = 0; i < lexemes && !open_str; i++) begin
      if (i > 0 && $urandom_range(0, 3) != 0) add_byte(pick_blank());
      case ($urandom_range(0, 15))
        0, 1, 2, 3: begin
          add_text(kw_spell[$urandom_range(0, NUM_KW-1)], 1'b1);
          if ($urandom_range(0, 5) == 0) add_byte(pick_word());
        end
        4, 5: begin
          add_byte(pick_lead());
          repeat ($urandom_range(0, 9)) add_byte(pick_word());
        end
        6: begin
          repeat ($urandom_range(1, 4)) add_byte(8'("0" + $urandom_range(0, 9)));
          if ($urandom_range(0, 1)) begin
            add_byte(CH_DOT);
            repeat ($urandom_range(0, 3)) add_byte(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 5) == 0) add_byte(CH_DOT);
          end
        end
        7: begin
          add_byte(CH_QUOTE);
          repeat ($urandom_range(0, 6)) add_byte(pick_content());
          if ($urandom_range(0, 9) == 0) open_str = 1'b1;
          else add_byte(CH_QUOTE);
        end
        8, 9: add_text(op_text[$urandom_range(0, 6)], 1'b0);
        10, 11: add_byte(punct_set[$urandom_range(0, 7)]);
        12: add_byte(CH_EQ);
        13: add_byte(8'($urandom_range(0, 255)));
        default: repeat ($urandom_range(1, 3)) add_byte(pick_blank());
      endcase
    end
    add_byte(CH_NUL);
  endfunction

  // reset and stimulus
  initial begin
    int mark;
    rst_ni              = 1'b0;
    bytes_if.valid      = 1'b0;
    bytes_if.char_code  = '0;
    tokens_if.ready     = 1'b0;
    clear_scan();

    foreach (directed_rows[i]) stim.push_back(directed_rows[i]);

    // saturated identifier and string lengths
    add_byte(pick_lead(), 1'b1);
    repeat (299) add_byte(pick_word());
    add_byte(CH_SPACE);
    add_byte(CH_QUOTE);
    repeat (LONG_STRING) add_byte(pick_content());
    add_byte(CH_QUOTE);
    add_text("x>=9;", 1'b0);
    add_byte(CH_NUL);

    // random statements, the first one sent only once the scanner has drained
    mark = stim.size();
    while (stim.size() < TOTAL_ITEMS) add_statement();
    stim[mark].hold = 1'b1;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // token check, byte prediction, sender and receiver
  always @(posedge clk_i) begin : bench_seq
    tok_t       got;
    tok_t       want;
    tok_t       toks [2];
    int         n;
    logic       nxt_valid;
    logic [7:0] nxt_code;
    logic       rdy;
    if (rst_ni) begin
      cycle_cnt++;

      // token beat against the oldest expectation
      if (tokens_if.valid && tokens_if.ready) begin
        got = '{tokens_if.token_kind, tokens_if.token_start, tokens_if.token_length,
                tokens_if.last_in_run};
        if (tokens_due.size() == 0) begin
          $error("token with none expected: kind %0d start %0d length %0d",
                 got.kind, got.start, got.length);
          errors++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", 16'(want.kind), 16'(got.kind));
          check_field("token_start", want.start, got.start);
          check_field("token_length", 16'(want.length), 16'(got.length));
          check_field("last_in_run", 16'(want.last), 16'(got.last));
        end
      end

      // byte beat taken: predict its tokens
      nxt_valid = bytes_if.valid;
      nxt_code  = bytes_if.char_code;
      if (bytes_if.valid && bytes_if.ready) begin
        lex_byte(stim[drv_idx].code, toks, n);
        if (stim[drv_idx].typed) tokens_due.push_back(stim[drv_idx].tok);
        else for (int i = 0; i < n; i++) tokens_due.push_back(toks[i]);
        drv_idx++;
        nxt_valid = 1'b0;
      end

      // sender: bursts with gaps, holding where a drained scanner is wanted
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (drv_idx < stim.size() &&
                     (!stim[drv_idx].hold || tokens_due.size() == 0)) begin
          nxt_valid = 1'b1;
          nxt_code  = stim[drv_idx].code;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            gap_left   = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
          end
        end
      end
      bytes_if.valid     <= nxt_valid;
      bytes_if.char_code <= nxt_code;

      // receiver: ready always, at random, or by a fixed stall pattern; style redrawn periodically
      if (cycle_cnt % 64 == 0) rx_style = $urandom_range(0, 2);
      case (rx_style)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        default: rdy = STALL_PAT[cycle_cnt % 16];
      endcase
      tokens_if.ready <= rdy;
    end
  end

  // end of run: all bytes taken, no tokens due, then a quiet tail
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < TAIL_CYCLES && cycle_cnt < CYCLE_LIMIT) begin
      @(negedge clk_i);
      if (rst_ni && drv_idx == stim.size() && tokens_due.size() == 0) quiet++;
      else quiet = 0;
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** sql_token_scanner: FAILED **");
    end else if (errors == 0) begin
      $display("** sql_token_scanner: PASSED **");
    end else begin
      $display("** sql_token_scanner: FAILED **");
    end
    $finish;
  end

endmodule
